// File: src/ptc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared constants and types of the pressure / temperature compensation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_COEFFS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_LOW    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_HIGH   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_NINE   = 2'd3;

   // quotient is saturated at 2^35, so 35 restoring steps plus an overflow check
   localparam int DIV_STEPS = 35;
   localparam int DIV_CMP_W = 64 + DIV_STEPS - 16 + 1 + 16 + 2;   // 102 bits

   // front stages, overflow check, divider steps, two product stages, output
   localparam int FRONT_STAGES = 12;
   localparam int LATENCY      = FRONT_STAGES + 1 + DIV_STEPS + 3;

   typedef struct packed {
      logic signed [15:0] tc;
      logic signed [24:0] tf;
      logic               dz;
      logic               neg;
      logic               ovf;
   } side_type;

endpackage

// File: src/pressure_temp_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Burst unpacking, calibrated temperature and Q24.8 pressure compensation.
// ----------------------------------------------------------------------------
// A burst is taken in every cycle (busy is low except during reset); its word
// passes the front stages, the divider and the post stages to the rsp_ ports,
// strobed by rsp_valid for one cycle; the receiver cannot stall. The pressure
// quotient uses a 35-step restoring divider, one step per stage, between
// multiplier stages. The user must write the calibration registers through
// the csr_ port only while no burst is in flight; the block does not check it.
module pressure_temp_compensation (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [7:0]                            req_press_msb,
   input  logic [7:0]                            req_press_lsb,
   input  logic [7:0]                            req_press_xlsb,
   input  logic [7:0]                            req_temp_msb,
   input  logic [7:0]                            req_temp_lsb,
   input  logic [7:0]                            req_temp_xlsb,
   output logic                                  rsp_valid,
   output logic signed [15:0]                    rsp_temp_centi,
   output logic signed [31:0]                    rsp_fine_temp,
   output logic [31:0]                           rsp_pressure_q8,
   output logic                                  rsp_div_zero,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ptc_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ptc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int LAT  = ptc_pkg::LATENCY;
   localparam int NDIV = ptc_pkg::DIV_STEPS;
   localparam int CW   = ptc_pkg::DIV_CMP_W;

   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_nine_ff;

   logic [LAT-1:0] vld_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_low_ff   <= '0;
         press_high_ff  <= '0;
         press_nine_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ptc_pkg::REG_TEMP_COEFFS: temp_coeffs_ff <= csr_wdata[47:0];
            ptc_pkg::REG_PRESS_LOW:   press_low_ff   <= csr_wdata;
            ptc_pkg::REG_PRESS_HIGH:  press_high_ff  <= csr_wdata;
            ptc_pkg::REG_PRESS_NINE:  press_nine_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start && !busy};
      end
   end

   logic        [15:0] t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = $signed(temp_coeffs_ff[31:16]);
   assign t3 = $signed(temp_coeffs_ff[47:32]);
   assign p1 = press_low_ff[15:0];
   assign p2 = $signed(press_low_ff[31:16]);
   assign p3 = $signed(press_low_ff[47:32]);
   assign p4 = $signed(press_low_ff[63:48]);
   assign p5 = $signed(press_high_ff[15:0]);
   assign p6 = $signed(press_high_ff[31:16]);
   assign p7 = $signed(press_high_ff[47:32]);
   assign p8 = $signed(press_high_ff[63:48]);
   assign p9 = $signed(press_nine_ff);

   // stage 0: unpack
   logic [19:0] adcp0_ff, adct0_ff;
   always_ff @(posedge clock) begin
      adcp0_ff <= {req_press_msb, req_press_lsb, req_press_xlsb[7:4]};
      adct0_ff <= {req_temp_msb, req_temp_lsb, req_temp_xlsb[7:4]};
   end

   // stage 1: temperature products
   logic signed [17:0] tlin;
   logic signed [16:0] tdif;
   logic signed [33:0] tprod1_ff, dsq1_ff;
   logic [19:0] adcp1_ff;
   assign tlin = $signed({1'b0, adct0_ff[19:3]}) - $signed({1'b0, t1, 1'b0});
   assign tdif = $signed({1'b0, adct0_ff[19:4]}) - $signed({1'b0, t1});
   always_ff @(posedge clock) begin
      tprod1_ff <= tlin * t2;
      dsq1_ff   <= tdif * tdif;
      adcp1_ff  <= adcp0_ff;
   end

   // stage 2
   logic signed [21:0] dsh;
   logic signed [22:0] v1t2_ff;
   logic signed [37:0] tprod2_ff;
   logic [19:0] adcp2_ff;
   assign dsh = dsq1_ff[33:12];
   always_ff @(posedge clock) begin
      v1t2_ff   <= tprod1_ff[33:11];
      tprod2_ff <= dsh * t3;
      adcp2_ff  <= adcp1_ff;
   end

   // stage 3: fine temperature
   logic signed [24:0] tf3_ff;
   logic [19:0] adcp3_ff;
   always_ff @(posedge clock) begin
      tf3_ff   <= {{2{v1t2_ff[22]}}, v1t2_ff} + {tprod2_ff[37], tprod2_ff[37:14]};
      adcp3_ff <= adcp2_ff;
   end

   // stage 4: centidegrees, pressure offset term
   logic signed [27:0] tf5;
   logic signed [19:0] tcr;
   logic signed [15:0] tc_sat;
   logic signed [15:0] tc4_ff;
   logic signed [24:0] tf4_ff;
   logic signed [25:0] pv4_ff;
   logic [19:0] adcp4_ff;
   assign tf5 = {{3{tf3_ff[24]}}, tf3_ff} + {tf3_ff[24], tf3_ff, 2'b00} + 28'sd128;
   assign tcr = tf5[27:8];
   always_comb begin
      if (tcr > 20'sd32767) begin
         tc_sat = 16'sh7fff;
      end else if (tcr < -20'sd32768) begin
         tc_sat = -16'sh8000;
      end else begin
         tc_sat = tcr[15:0];
      end
   end
   always_ff @(posedge clock) begin
      tc4_ff   <= tc_sat;
      tf4_ff   <= tf3_ff;
      pv4_ff   <= {tf3_ff[24], tf3_ff} - 26'sd128000;
      adcp4_ff <= adcp3_ff;
   end

   // stage 5
   logic signed [51:0] vsq5_ff;
   logic signed [41:0] vp5_5_ff, vp2_5_ff;
   logic signed [15:0] tc5_ff;
   logic signed [24:0] tf5_ff;
   logic [19:0] adcp5_ff;
   always_ff @(posedge clock) begin
      vsq5_ff  <= pv4_ff * pv4_ff;
      vp5_5_ff <= pv4_ff * p5;
      vp2_5_ff <= pv4_ff * p2;
      tc5_ff   <= tc4_ff;
      tf5_ff   <= tf4_ff;
      adcp5_ff <= adcp4_ff;
   end

   // stage 6
   logic signed [67:0] m6_6_ff, m3_6_ff;
   logic signed [41:0] vp5_6_ff, vp2_6_ff;
   logic signed [15:0] tc6_ff;
   logic signed [24:0] tf6_ff;
   logic [19:0] adcp6_ff;
   always_ff @(posedge clock) begin
      m6_6_ff  <= vsq5_ff * p6;
      m3_6_ff  <= vsq5_ff * p3;
      vp5_6_ff <= vp5_5_ff;
      vp2_6_ff <= vp2_5_ff;
      tc6_ff   <= tc5_ff;
      tf6_ff   <= tf5_ff;
      adcp6_ff <= adcp5_ff;
   end

   // stage 7: v2 and divisor polynomial
   logic signed [63:0] m6w, m3w, vp5w, vp2w, p4w;
   logic signed [63:0] v2_7_ff, a7_ff;
   logic signed [15:0] tc7_ff;
   logic signed [24:0] tf7_ff;
   logic [19:0] adcp7_ff;
   assign m6w  = $signed(m6_6_ff[63:0]);
   assign m3w  = $signed(m3_6_ff[63:0]);
   assign vp5w = {{22{vp5_6_ff[41]}}, vp5_6_ff};
   assign vp2w = {{22{vp2_6_ff[41]}}, vp2_6_ff};
   assign p4w  = {{48{p4[15]}}, p4};
   always_ff @(posedge clock) begin
      v2_7_ff  <= m6w + (vp5w <<< 17) + (p4w <<< 35);
      a7_ff    <= 64'sh0000_8000_0000_0000 + (m3w >>> 8) + (vp2w <<< 12);
      tc7_ff   <= tc6_ff;
      tf7_ff   <= tf6_ff;
      adcp7_ff <= adcp6_ff;
   end

   // stage 8: split product with P1
   logic signed [46:0] ah;
   logic signed [63:0] ahp8_ff, v2_8_ff;
   logic [32:0] alp8_ff;
   logic signed [15:0] tc8_ff;
   logic signed [24:0] tf8_ff;
   logic [19:0] adcp8_ff;
   assign ah = a7_ff[63:17];
   always_ff @(posedge clock) begin
      ahp8_ff  <= ah * $signed({1'b0, p1});
      alp8_ff  <= a7_ff[16:0] * p1;
      v2_8_ff  <= v2_7_ff;
      tc8_ff   <= tc7_ff;
      tf8_ff   <= tf7_ff;
      adcp8_ff <= adcp7_ff;
   end

   // stage 9: divisor, saturated dividend
   logic signed [63:0] dsum, pshift, nraw;
   logic signed [21:0] pp;
   logic signed [52:0] nsat;
   logic signed [47:0] div9_ff;
   logic signed [52:0] num9_ff;
   logic signed [15:0] tc9_ff;
   logic signed [24:0] tf9_ff;
   assign dsum   = ahp8_ff + $signed({48'b0, alp8_ff[32:17]});
   assign pp     = 22'sd1048576 - $signed({2'b00, adcp8_ff});
   assign pshift = {{42{pp[21]}}, pp} <<< 31;
   assign nraw   = pshift - v2_8_ff;
   always_comb begin
      if (nraw > 64'sh0008_0000_0000_0000) begin
         nsat = 53'sh08_0000_0000_0000;
      end else if (nraw < -64'sh0008_0000_0000_0000) begin
         nsat = -53'sh08_0000_0000_0000;
      end else begin
         nsat = nraw[52:0];
      end
   end
   always_ff @(posedge clock) begin
      div9_ff <= dsum[63:16];
      num9_ff <= nsat;
      tc9_ff  <= tc8_ff;
      tf9_ff  <= tf8_ff;
   end

   // stage 10: scale dividend, divisor magnitude
   logic signed [65:0] n3_10_ff;
   logic [47:0] dmag10_ff;
   ptc_pkg::side_type side10_ff;
   always_ff @(posedge clock) begin
      n3_10_ff       <= num9_ff * 14'sd3125;
      dmag10_ff      <= div9_ff[47] ? 48'(-div9_ff) : 48'(div9_ff);
      side10_ff.tc   <= tc9_ff;
      side10_ff.tf   <= tf9_ff;
      side10_ff.dz   <= (div9_ff == '0);
      side10_ff.neg  <= num9_ff[52] ^ div9_ff[47];
      side10_ff.ovf  <= 1'b0;
   end

   // stage 11: dividend magnitude
   logic [63:0] nmag11_ff;
   logic [47:0] dmag11_ff;
   ptc_pkg::side_type side11_ff;
   always_ff @(posedge clock) begin
      nmag11_ff <= n3_10_ff[65] ? 64'(-n3_10_ff) : 64'(n3_10_ff);
      dmag11_ff <= dmag10_ff;
      side11_ff <= side10_ff;
   end

   // divider: overflow check, then one restoring step per stage
   logic [63:0]         rem_ff  [0:NDIV];
   logic [NDIV-1:0]     quo_ff  [0:NDIV];
   logic [47:0]         dmag_ff [0:NDIV];
   ptc_pkg::side_type   side_ff [0:NDIV];
   logic [63:0]         rem_in  [1:NDIV];
   logic [NDIV-1:0]     quo_in  [1:NDIV];
   logic [CW-1:0]       dsh_v   [1:NDIV];
   ptc_pkg::side_type   side0_in;

   always_comb begin
      side0_in     = side11_ff;
      side0_in.ovf = {{(CW-64){1'b0}}, nmag11_ff} >= {{(CW-48-NDIV){1'b0}}, dmag11_ff, {NDIV{1'b0}}};
   end

   always_comb begin
      for (int k = 1; k <= NDIV; k++) begin
         dsh_v[k]  = {{(CW-48){1'b0}}, dmag_ff[k-1]} << (NDIV - k);
         rem_in[k] = rem_ff[k-1];
         quo_in[k] = quo_ff[k-1];
         if ({{(CW-64){1'b0}}, rem_ff[k-1]} >= dsh_v[k]) begin
            rem_in[k]          = rem_ff[k-1] - dsh_v[k][63:0];
            quo_in[k][NDIV-k]  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= nmag11_ff;
      quo_ff[0]  <= '0;
      dmag_ff[0] <= dmag11_ff;
      side_ff[0] <= side0_in;
      for (int k = 1; k <= NDIV; k++) begin
         rem_ff[k]  <= rem_in[k];
         quo_ff[k]  <= quo_in[k];
         dmag_ff[k] <= dmag_ff[k-1];
         side_ff[k] <= side_ff[k-1];
      end
   end

   // post stage A: signed quotient, products
   logic [NDIV:0] qmag;
   logic signed [NDIV+1:0] qsig;
   logic signed [23:0] ps;
   logic signed [47:0] psq_a_ff;
   logic signed [52:0] p8p_a_ff;
   logic signed [NDIV+1:0] q_a_ff;
   ptc_pkg::side_type side_a_ff;
   assign qmag = side_ff[NDIV].ovf ? {1'b1, {NDIV{1'b0}}} : {1'b0, quo_ff[NDIV]};
   assign qsig = side_ff[NDIV].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
   assign ps   = qsig[NDIV+1:13];
   always_ff @(posedge clock) begin
      psq_a_ff  <= ps * ps;
      p8p_a_ff  <= qsig * p8;
      q_a_ff    <= qsig;
      side_a_ff <= side_ff[NDIV];
   end

   // post stage B
   logic signed [63:0] v1q;
   logic signed [38:0] v1p_b_ff;
   logic signed [33:0] v2p_b_ff;
   logic signed [NDIV+1:0] q_b_ff;
   ptc_pkg::side_type side_b_ff;
   assign v1q = psq_a_ff * p9;
   always_ff @(posedge clock) begin
      v1p_b_ff  <= v1q[63:25];
      v2p_b_ff  <= p8p_a_ff[52:19];
      q_b_ff    <= q_a_ff;
      side_b_ff <= side_a_ff;
   end

   // output stage
   logic signed [39:0] psum;
   logic signed [33:0] pfin;
   logic [31:0] pq;
   logic signed [15:0] rsp_tc_ff;
   logic signed [31:0] rsp_tf_ff;
   logic [31:0] rsp_pq_ff;
   logic rsp_dz_ff;
   assign psum = {{(40-NDIV-2){q_b_ff[NDIV+1]}}, q_b_ff}
               + {v1p_b_ff[38], v1p_b_ff}
               + {{6{v2p_b_ff[33]}}, v2p_b_ff};
   assign pfin = {{2{psum[39]}}, psum[39:8]} + {{14{p7[15]}}, p7, 4'b0000};
   always_comb begin
      if (side_b_ff.dz || pfin[33]) begin
         pq = '0;
      end else if (pfin[32]) begin
         pq = '1;
      end else begin
         pq = pfin[31:0];
      end
   end
   always_ff @(posedge clock) begin
      rsp_tc_ff <= side_b_ff.tc;
      rsp_tf_ff <= {{7{side_b_ff.tf[24]}}, side_b_ff.tf};
      rsp_pq_ff <= pq;
      rsp_dz_ff <= side_b_ff.dz;
   end

   assign rsp_valid       = vld_ff[LAT-1];
   assign rsp_temp_centi  = rsp_tc_ff;
   assign rsp_fine_temp   = rsp_tf_ff;
   assign rsp_pressure_q8 = rsp_pq_ff;
   assign rsp_div_zero    = rsp_dz_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_zero |-> rsp_pressure_q8 == 32'd0)
      else $error("pressure not cleared on zero divisor");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(LAT) rsp_valid)
      else $error("result missing after pipeline latency");

   a_tc_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fine_temp > 32'sd2000000 |-> rsp_temp_centi == 16'sh7fff)
      else $error("temperature not saturated");

endmodule

// File: verif/pressure_temp_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_temp_compensation_tb
// Self-checking bench for the burst compensation block. The bench drives
// sensor bursts with random gaps and walks through several calibration sets:
// reset zeros, typical sensor data, all-ones, signed extremes and random sets.
// A scoreboard predicts temperature, fine temperature, Q24.8 pressure and the
// divide-by-zero flag in 64-bit integer arithmetic, then checks each rsp_ word
// in order against its prediction.
// ----------------------------------------------------------------------------
module pressure_temp_compensation_tb;

   typedef struct {
      logic [7:0] pm, pl, px, tm, tl, tx;
   } burst_type;

   typedef struct {
      logic signed [15:0] tc;
      logic signed [31:0] tf;
      logic [31:0]        pq;
      logic               dz;
   } comp_word_type;

   class comp_scoreboard;
      logic [47:0] temp_cal;
      logic [63:0] press_lo, press_hi;
      logic [15:0] press_p9;
      comp_word_type pending[$];
      int          errors;

      function new();
         temp_cal = '0; press_lo = '0; press_hi = '0; press_p9 = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [ptc_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] val);
         case (idx)
            ptc_pkg::REG_TEMP_COEFFS: temp_cal = val[47:0];
            ptc_pkg::REG_PRESS_LOW:   press_lo = val;
            ptc_pkg::REG_PRESS_HIGH:  press_hi = val;
            ptc_pkg::REG_PRESS_NINE:  press_p9 = val[15:0];
            default: ;
         endcase
      endfunction

      function longint sx(logic [15:0] v);
         return longint'(signed'(v));
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function comp_word_type compensate(burst_type b);
         comp_word_type w;
         longint adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         longint v1, v2, d, tf, tc, a, ah, al, dv, num, p;
         adc_p = longint'({b.pm, b.pl, b.px[7:4]});
         adc_t = longint'({b.tm, b.tl, b.tx[7:4]});
         t1 = longint'(temp_cal[15:0]);
         t2 = sx(temp_cal[31:16]);
         t3 = sx(temp_cal[47:32]);
         p1 = longint'(press_lo[15:0]);
         p2 = sx(press_lo[31:16]);
         p3 = sx(press_lo[47:32]);
         p4 = sx(press_lo[63:48]);
         p5 = sx(press_hi[15:0]);
         p6 = sx(press_hi[31:16]);
         p7 = sx(press_hi[47:32]);
         p8 = sx(press_hi[63:48]);
         p9 = sx(press_p9);
         v1 = (((adc_t >>> 3) - 2 * t1) * t2) >>> 11;
         d  = (adc_t >>> 4) - t1;
         v2 = (((d * d) >>> 12) * t3) >>> 14;
         tf = v1 + v2;
         tc = clip((tf * 5 + 128) >>> 8, -32768, 32767);
         w.tc = tc[15:0];
         w.tf = tf[31:0];
         w.pq = '0;
         w.dz = 1'b0;
         v1 = tf - 128000;
         v2 = v1 * v1 * p6;
         v2 += v1 * p5 * (longint'(1) <<< 17);
         v2 += p4 * (longint'(1) <<< 35);
         a  = (longint'(1) <<< 47) + ((v1 * v1 * p3) >>> 8) + v1 * p2 * 4096;
         ah = a >>> 17;
         al = a - ah * 131072;
         dv = (ah * p1 + ((al * p1) >>> 17)) >>> 16;
         if (dv == 0) begin
            w.dz = 1'b1;
         end else begin
            p   = 1048576 - adc_p;
            num = clip(p * (longint'(1) <<< 31) - v2,
                       -(longint'(1) <<< 51), longint'(1) <<< 51);
            p   = clip((num * 3125) / dv, -(longint'(1) <<< 35), longint'(1) <<< 35);
            v1  = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
            v2  = (p8 * p) >>> 19;
            p   = ((p + v1 + v2) >>> 8) + p7 * 16;
            p   = clip(p, 0, longint'(64'hFFFF_FFFF));
            w.pq = p[31:0];
         end
         return w;
      endfunction

      function void note_burst(burst_type b);
         pending.push_back(compensate(b));
      endfunction

      task report(string what, longint got, longint exp);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
         errors++;
      endtask

      task check_word(comp_word_type got);
         comp_word_type e;
         if (pending.size() == 0) begin
            report("unexpected word", 0, 0);
         end else begin
            e = pending.pop_front();
            if (got.tc !== e.tc) report("temp_centi", got.tc, e.tc);
            if (got.tf !== e.tf) report("fine_temp", got.tf, e.tf);
            if (got.pq !== e.pq) report("pressure_q8", got.pq, e.pq);
            if (got.dz !== e.dz) report("div_zero", got.dz, e.dz);
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [7:0]             req_press_msb = '0, req_press_lsb = '0, req_press_xlsb = '0;
   logic [7:0]             req_temp_msb = '0, req_temp_lsb = '0, req_temp_xlsb = '0;
   logic                   rsp_valid;
   logic signed [15:0]     rsp_temp_centi;
   logic signed [31:0]     rsp_fine_temp;
   logic [31:0]            rsp_pressure_q8;
   logic                   rsp_div_zero;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [ptc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ptc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   comp_scoreboard sb = new();
   int unsigned    cycles = 0;

   pressure_temp_compensation i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 600000) begin
         $display("[pressure_temp_compensation] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      burst_type b;
      comp_word_type w;
      if (!reset && start && !busy) begin
         b.pm = req_press_msb; b.pl = req_press_lsb; b.px = req_press_xlsb;
         b.tm = req_temp_msb;  b.tl = req_temp_lsb;  b.tx = req_temp_xlsb;
         sb.note_burst(b);
      end
      if (!reset && rsp_valid) begin
         w.tc = rsp_temp_centi; w.tf = rsp_fine_temp;
         w.pq = rsp_pressure_q8; w.dz = rsp_div_zero;
         sb.check_word(w);
      end
   end

   task send_burst(burst_type b);
      int gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_press_msb <= b.pm; req_press_lsb <= b.pl; req_press_xlsb <= b.px;
      req_temp_msb  <= b.tm; req_temp_lsb  <= b.tl; req_temp_xlsb  <= b.tx;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task drain;
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (ptc_pkg::LATENCY + 4) @(posedge clock);
   endtask

   task write_reg(logic [ptc_pkg::CSR_INDEX_W-1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task load_cal(logic [47:0] t, logic [63:0] lo, logic [63:0] hi, logic [15:0] p9);
      write_reg(ptc_pkg::REG_TEMP_COEFFS, {$urandom, $urandom});
      write_reg(ptc_pkg::REG_TEMP_COEFFS, {16'(0), t});
      write_reg(ptc_pkg::REG_PRESS_LOW, lo);
      write_reg(ptc_pkg::REG_PRESS_HIGH, hi);
      write_reg(ptc_pkg::REG_PRESS_NINE, {48'(0), p9});
   endtask

   function burst_type rand_burst();
      burst_type b;
      b.pm = 8'($urandom); b.pl = 8'($urandom); b.px = 8'($urandom);
      b.tm = 8'($urandom); b.tl = 8'($urandom); b.tx = 8'($urandom);
      if ($urandom_range(0, 3) != 0) begin
         // typical sensor range
         b.pm = 8'($urandom_range(8'h40, 8'h70));
         b.tm = 8'($urandom_range(8'h70, 8'h90));
      end
      return b;
   endfunction

   task run_directed;
      burst_type b;
      for (int i = 0; i < 20; i++) begin
         case (i % 5)
            0: b = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            1: b = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
            2: b = '{8'h00, 8'h00, 8'h0F, 8'hFF, 8'hFF, 8'hF0};
            3: b = '{8'hFF, 8'hFF, 8'hF0, 8'h00, 8'h00, 8'h0F};
            default: b = '{8'h65, 8'h5A, 8'hC0, 8'h7E, 8'hED, 8'h00};
         endcase
         if (i >= 5) b = rand_burst();
         send_burst(b);
      end
   endtask

   task run_random(int n);
      for (int i = 0; i < n; i++) send_burst(rand_burst());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset calibration: divisor is zero
      run_directed();
      run_random(150);
      drain();

      // typical sensor calibration
      load_cal({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
      run_directed();
      run_random(400);
      drain();

      load_cal('1, '1, '1, '1);
      run_directed();
      run_random(200);
      drain();

      load_cal({16'h7FFF, 16'h7FFF, 16'hFFFF}, {{3{16'h7FFF}}, 16'hFFFF},
               {4{16'h7FFF}}, 16'h7FFF);
      run_directed();
      run_random(200);
      drain();

      load_cal({16'h8000, 16'h8000, 16'h0000}, {{3{16'h8000}}, 16'h0001},
               {4{16'h8000}}, 16'h8000);
      run_directed();
      run_random(200);
      drain();

      for (int k = 0; k < 4; k++) begin
         load_cal(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
         run_random(200);
         drain();
      end

      if (sb.errors == 0) begin
         $display("[pressure_temp_compensation] OK");
      end else begin
         $display("[pressure_temp_compensation] ERROR");
      end
      $finish;
   end

endmodule
